// ===== design/drt_pkg.sv =====
// Shared types and constants for the data run decoder and translator.
`timescale 1ns / 1ps
`default_nettype none
package drt_pkg;

  localparam int unsigned MAX_RUNS = 64;
  localparam int unsigned IdxW = $clog2(MAX_RUNS);
  localparam int unsigned CntW = $clog2(MAX_RUNS + 1);

  localparam logic [1:0] StatusOk = 2'd0;
  localparam logic [1:0] StatusOversize = 2'd1;
  localparam logic [1:0] StatusFull = 2'd2;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_BYTE,
    OP_LATCH,
    OP_SHIFT,
    OP_READ,
    OP_SUB,
    OP_NEXT,
    OP_MAP,
    OP_HIT,
    OP_MISS
  } drt_op_e;

  typedef struct packed {
    drt_op_e op;
  } drt_cmd_t;

  typedef struct packed {
    logic out_free;
    logic empty;
    logic last;
    logic hit;
  } drt_stat_t;

endpackage
`default_nettype wire

// ===== design/drt_ctrl.sv =====
// Controller state machine that sequences byte decoding and run table searches.
`timescale 1ns / 1ps
`default_nettype none
module drt_ctrl
  import drt_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  input  wire logic      kind_i,
  output logic           in_stall_o,
  input  wire drt_stat_t stat_i,
  output drt_cmd_t       cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT,
    S_READ,
    S_SUB,
    S_CMP,
    S_MAP,
    S_HIT,
    S_MISS
  } state_e;

  state_e state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE) || !stat_i.out_free;

  always_comb begin
    state_d = state_q;
    cmd_o.op = OP_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && stat_i.out_free) begin
          if (kind_i) begin
            cmd_o.op = OP_LATCH;
            state_d = S_SHIFT;
          end else begin
            cmd_o.op = OP_BYTE;
          end
        end
      end
      S_SHIFT: begin
        cmd_o.op = OP_SHIFT;
        state_d = stat_i.empty ? S_MISS : S_READ;
      end
      S_READ: begin
        cmd_o.op = OP_READ;
        state_d = S_SUB;
      end
      S_SUB: begin
        cmd_o.op = OP_SUB;
        state_d = S_CMP;
      end
      S_CMP: begin
        priority if (stat_i.hit) begin
          state_d = S_MAP;
        end else if (stat_i.last) begin
          state_d = S_MISS;
        end else begin
          cmd_o.op = OP_NEXT;
          state_d = S_READ;
        end
      end
      S_MAP: begin
        cmd_o.op = OP_MAP;
        state_d = S_HIT;
      end
      S_HIT: begin
        if (stat_i.out_free) begin
          cmd_o.op = OP_HIT;
          state_d = S_IDLE;
        end
      end
      S_MISS: begin
        if (stat_i.out_free) begin
          cmd_o.op = OP_MISS;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

// ===== design/drt_dp.sv =====
// Datapath: run-list byte decoding, run table memory, search arithmetic and result register.
`timescale 1ns / 1ps
`default_nettype none
module drt_dp
  import drt_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire drt_cmd_t    cmd_i,
  output drt_stat_t        stat_o,
  input  wire logic [4:0]  cluster_shift_i,
  input  wire logic [4:0]  record_shift_i,
  input  wire logic [7:0]  run_byte_i,
  input  wire logic [47:0] record_index_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       status_o,
  output logic             run_done_o,
  output logic             list_end_o,
  output logic [63:0]      run_start_vcn_o,
  output logic [63:0]      run_start_lcn_o,
  output logic [63:0]      run_clusters_o,
  output logic             found_o,
  output logic [63:0]      byte_offset_o
);

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_LENGTH = 2'd1,
    PH_OFFSET = 2'd2
  } phase_e;

  typedef struct packed {
    logic [63:0] vcn;
    logic [63:0] lcn;
    logic [63:0] len;
  } run_t;

  run_t run_mem [MAX_RUNS];
  run_t rd_q;

  logic [1:0]  phase_q, phase_d;
  logic [3:0]  left_q, left_d;
  logic [2:0]  pos_q, pos_d;
  logic [3:0]  ob_q, ob_d;
  logic [63:0] len_acc_q, len_acc_d;
  logic [63:0] off_acc_q, off_acc_d;
  logic [63:0] next_vcn_q, next_vcn_d;
  logic [63:0] cur_lcn_q, cur_lcn_d;
  logic [CntW-1:0] count_q, count_d;

  logic [47:0] index_q;
  logic [63:0] vcn_q, within_q, diff_q, clus_q;
  logic        borrow_q;
  logic [IdxW-1:0] idx_q;

  logic        ov_q, ov_d;
  logic [1:0]  st_q, st_d;
  logic        rd_q_done, rd_d_done;
  logic        le_q, le_d;
  logic [63:0] rv_q, rv_d, rl_q, rl_d, rc_q, rc_d;
  logic        fd_q, fd_d;
  logic [63:0] bo_q, bo_d;

  logic        wr_en;
  logic [63:0] byte_val, len_new, off_new, off_ext, bytes_w;
  logic [3:0]  left_dec;
  logic [64:0] sub_w;

  assign stat_o.out_free = !ov_q || !out_stall_i;
  assign stat_o.empty = (count_q == '0);
  assign stat_o.last = ({1'b0, idx_q} + CntW'(1)) >= count_q;
  assign stat_o.hit = !borrow_q && (diff_q < rd_q.len);

  assign bytes_w = {16'd0, index_q} << record_shift_i;
  assign sub_w = {1'b0, vcn_q} - {1'b0, rd_q.vcn};
  assign byte_val = 64'(run_byte_i) << {pos_q, 3'b000};
  assign len_new = (phase_q == PH_LENGTH) ? (len_acc_q | byte_val) : len_acc_q;
  assign off_new = (phase_q == PH_OFFSET) ? (off_acc_q | byte_val) : off_acc_q;
  assign left_dec = (left_q != 4'd0) ? (left_q - 4'd1) : 4'd0;

  // Sign-extend the relative offset from its encoded byte count.
  always_comb begin
    off_ext = off_new;
    unique case (ob_q)
      4'd1: off_ext = {{56{off_new[7]}}, off_new[7:0]};
      4'd2: off_ext = {{48{off_new[15]}}, off_new[15:0]};
      4'd3: off_ext = {{40{off_new[23]}}, off_new[23:0]};
      4'd4: off_ext = {{32{off_new[31]}}, off_new[31:0]};
      4'd5: off_ext = {{24{off_new[39]}}, off_new[39:0]};
      4'd6: off_ext = {{16{off_new[47]}}, off_new[47:0]};
      4'd7: off_ext = {{8{off_new[55]}}, off_new[55:0]};
      default: off_ext = off_new;
    endcase
  end

  always_comb begin
    phase_d = phase_q;
    left_d = left_q;
    pos_d = pos_q;
    ob_d = ob_q;
    len_acc_d = len_acc_q;
    off_acc_d = off_acc_q;
    next_vcn_d = next_vcn_q;
    cur_lcn_d = cur_lcn_q;
    count_d = count_q;
    wr_en = 1'b0;
    ov_d = ov_q && out_stall_i;
    st_d = st_q;
    rd_d_done = rd_q_done;
    le_d = le_q;
    rv_d = rv_q;
    rl_d = rl_q;
    rc_d = rc_q;
    fd_d = fd_q;
    bo_d = bo_q;
    if (cmd_i.op == OP_BYTE) begin
      if (phase_q == PH_LENGTH || phase_q == PH_OFFSET) begin
        len_acc_d = len_new;
        off_acc_d = off_new;
        pos_d = pos_q + 3'd1;
        left_d = left_dec;
        if (left_dec == 4'd0) begin
          if (phase_q == PH_LENGTH && ob_q != 4'd0) begin
            phase_d = PH_OFFSET;
            left_d = ob_q;
            pos_d = 3'd0;
          end else begin
            cur_lcn_d = cur_lcn_q + off_ext;
            ov_d = 1'b1;
            st_d = StatusOk;
            rd_d_done = 1'b0;
            le_d = 1'b0;
            fd_d = 1'b0;
            bo_d = '0;
            rv_d = next_vcn_q;
            rl_d = cur_lcn_q + off_ext;
            rc_d = len_new;
            if (count_q < CntW'(MAX_RUNS)) begin
              wr_en = 1'b1;
              count_d = count_q + CntW'(1);
              rd_d_done = 1'b1;
            end else begin
              st_d = StatusFull;
            end
            next_vcn_d = next_vcn_q + len_new;
            phase_d = PH_HEADER;
            left_d = 4'd0;
            pos_d = 3'd0;
          end
        end
      end else begin
        phase_d = PH_HEADER;
        if (run_byte_i == 8'd0) begin
          next_vcn_d = '0;
          cur_lcn_d = '0;
          ov_d = 1'b1;
          {st_d, rd_d_done, fd_d} = '0;
          le_d = 1'b1;
          {rv_d, rl_d, rc_d, bo_d} = '0;
        end else if (run_byte_i[3:0] > 4'd8 || run_byte_i[7:4] > 4'd8) begin
          ov_d = 1'b1;
          st_d = StatusOversize;
          {rd_d_done, le_d, fd_d} = '0;
          {rv_d, rl_d, rc_d, bo_d} = '0;
        end else begin
          len_acc_d = '0;
          off_acc_d = '0;
          ob_d = run_byte_i[7:4];
          pos_d = 3'd0;
          if (run_byte_i[3:0] != 4'd0) begin
            phase_d = PH_LENGTH;
            left_d = run_byte_i[3:0];
          end else begin
            phase_d = PH_OFFSET;
            left_d = run_byte_i[7:4];
          end
        end
      end
    end else if (cmd_i.op == OP_HIT || cmd_i.op == OP_MISS) begin
      ov_d = 1'b1;
      st_d = StatusOk;
      {rd_d_done, le_d} = '0;
      {rv_d, rl_d, rc_d} = '0;
      fd_d = (cmd_i.op == OP_HIT);
      bo_d = (cmd_i.op == OP_HIT) ? ((clus_q << cluster_shift_i) + within_q) : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      left_q <= '0;
      pos_q <= '0;
      ob_q <= '0;
      len_acc_q <= '0;
      off_acc_q <= '0;
      next_vcn_q <= '0;
      cur_lcn_q <= '0;
      count_q <= '0;
      ov_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      left_q <= left_d;
      pos_q <= pos_d;
      ob_q <= ob_d;
      len_acc_q <= len_acc_d;
      off_acc_q <= off_acc_d;
      next_vcn_q <= next_vcn_d;
      cur_lcn_q <= cur_lcn_d;
      count_q <= count_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    st_q <= st_d;
    rd_q_done <= rd_d_done;
    le_q <= le_d;
    rv_q <= rv_d;
    rl_q <= rl_d;
    rc_q <= rc_d;
    fd_q <= fd_d;
    bo_q <= bo_d;
  end

  // Run table and search registers.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      run_mem[count_q[IdxW-1:0]] <= '{vcn: next_vcn_q, lcn: cur_lcn_q + off_ext, len: len_new};
    end
    if (cmd_i.op == OP_READ) begin
      rd_q <= run_mem[idx_q];
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_LATCH: index_q <= record_index_i;
      OP_SHIFT: begin
        vcn_q <= bytes_w >> cluster_shift_i;
        within_q <= bytes_w & ((64'd1 << cluster_shift_i) - 64'd1);
        idx_q <= '0;
      end
      OP_SUB: begin
        diff_q <= sub_w[63:0];
        borrow_q <= sub_w[64];
      end
      OP_NEXT: idx_q <= idx_q + IdxW'(1);
      OP_MAP: clus_q <= rd_q.lcn + diff_q;
      default: ;
    endcase
  end

  assign out_valid_o = ov_q;
  assign status_o = st_q;
  assign run_done_o = rd_q_done;
  assign list_end_o = le_q;
  assign run_start_vcn_o = rv_q;
  assign run_start_lcn_o = rl_q;
  assign run_clusters_o = rc_q;
  assign found_o = fd_q;
  assign byte_offset_o = bo_q;

endmodule
`default_nettype wire

// ===== design/data_run_decoder_and_translator_top.sv =====
// Top level of the run-list decoder and record-to-disk translator.
//   channel  direction  handshake              payload
//   in       input      in_valid_i/in_stall_o  kind, run_byte, record_index
//   out      output     out_valid_o/out_stall_i status, run flags, run fields, found, offset
//   cfg      input      APB psel/penable       cluster_shift (0x0), record_shift (0x4)
// Each run-list byte's result, if any, is in the output register next cycle.
// A translation latches the index, shifts it to a cluster number, then reads, subtracts and
// compares each entry in turn; a hit maps the cluster and loads the result, while a miss or
// an empty table loads a miss result; the input reopens once the result is loaded.
// Reset clears the decoder state and run count; table contents stay undefined until written.
// Input stalls while a search runs or a result waits on a stalled output.
`timescale 1ns / 1ps
`default_nettype none
module data_run_decoder_and_translator_top
  import drt_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        kind_i,
  input  wire logic [7:0]  run_byte_i,
  input  wire logic [47:0] record_index_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       status_o,
  output logic             run_done_o,
  output logic             list_end_o,
  output logic [63:0]      run_start_vcn_o,
  output logic [63:0]      run_start_lcn_o,
  output logic [63:0]      run_clusters_o,
  output logic             found_o,
  output logic [63:0]      byte_offset_o
);

  logic [4:0] cluster_shift_q, record_shift_q;
  drt_cmd_t   cmd;
  drt_stat_t  stat;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? {27'd0, record_shift_q} : {27'd0, cluster_shift_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cluster_shift_q <= 5'd12;
      record_shift_q <= 5'd10;
    end else if (psel && penable && pwrite) begin
      if (paddr[2]) begin
        record_shift_q <= pwdata[4:0];
      end else begin
        cluster_shift_q <= pwdata[4:0];
      end
    end
  end

  drt_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .kind_i,
    .in_stall_o,
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  drt_dp u_dp (
    .clk_i,
    .rst_ni,
    .cmd_i           (cmd),
    .stat_o          (stat),
    .cluster_shift_i (cluster_shift_q),
    .record_shift_i  (record_shift_q),
    .run_byte_i,
    .record_index_i,
    .out_valid_o,
    .out_stall_i,
    .status_o,
    .run_done_o,
    .list_end_o,
    .run_start_vcn_o,
    .run_start_lcn_o,
    .run_clusters_o,
    .found_o,
    .byte_offset_o
  );

endmodule
`default_nettype wire

// ===== design/drt_checker.sv =====
// Port-level assertions for the decoder top level and the bind that attaches them.
`timescale 1ns / 1ps
`default_nettype none
module drt_checker
  import drt_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic        kind_i,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [1:0]  status_o,
  input wire logic        run_done_o,
  input wire logic        list_end_o,
  input wire logic        found_o,
  input wire logic [63:0] byte_offset_o
);

  // A held result keeps its offset.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(byte_offset_o))
    else $error("stalled result changed");

  // An accepted translation stalls the input in the cycle after it is taken.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && kind_i |=> in_stall_o)
    else $error("input taken during translation");

  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(run_done_o && list_end_o) && !(found_o && run_done_o))
    else $error("conflicting result flags");

  a_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> byte_offset_o == 64'd0)
    else $error("offset on a miss");

  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != StatusOk |-> !run_done_o && !found_o)
    else $error("error status with success flag");

endmodule

bind data_run_decoder_and_translator_top drt_checker u_drt_checker (
  .clk_i,
  .rst_ni,
  .in_valid_i,
  .in_stall_o,
  .kind_i,
  .out_valid_o,
  .out_stall_i,
  .status_o,
  .run_done_o,
  .list_end_o,
  .found_o,
  .byte_offset_o
);
`default_nettype wire
